@@ sv/bol_pkg.sv @@
// Shared types and codes for the bounded ordered list.
`timescale 1ns / 1ps

package bol_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int MAX_DEPTH     = 64;
    // Wide enough for any cell index up to MAX_DEPTH-1
    localparam int IDX_W         = 6;
    localparam int VAL_W         = 32;
    localparam int MODE_W        = 3;
    localparam int POS_W         = 5;
    localparam int TOTAL_W       = 6;
    localparam int STAT_W        = 2;
    localparam int S_DATA_W      = 40;
    localparam int M_DATA_W      = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_INSERT     = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_POP_BACK   = 3'd4,
        MODE_READ_ALL   = 3'd5,
        MODE_COUNT      = 3'd6,
        MODE_SPARE      = 3'd7
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    // Command broadcast along the chain
    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] pos;   // insert / remove slot
        logic [IDX_W-1:0] tail;  // last occupied slot, for rotation
    } cell_cmd_t;

endpackage

@@ sv/bol_cell.sv @@
// One slot of the list: holds an entry and trades it with its neighbours.
`timescale 1ns / 1ps

module bol_cell #(
    parameter int IDX = 0
) (
    input  logic                      aclk,
    input  bol_pkg::cell_cmd_t        cmd,
    input  logic [bol_pkg::VAL_W-1:0] ins_value,
    input  logic [bol_pkg::VAL_W-1:0] left_value,
    input  logic [bol_pkg::VAL_W-1:0] right_value,
    input  logic [bol_pkg::VAL_W-1:0] head_value,
    output logic [bol_pkg::VAL_W-1:0] value
);
    import bol_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        unique case (cmd.op)
            OP_HOLD: begin
                value_next = value_reg;
            end
            OP_INSERT: begin
                if (MY_IDX > cmd.pos) begin
                    value_next = left_value;
                end else if (MY_IDX == cmd.pos) begin
                    value_next = ins_value;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= cmd.pos) begin
                    value_next = right_value;
                end
            end
            OP_ROTATE: begin
                // front entry wraps round to the tail slot
                if (MY_IDX < cmd.tail) begin
                    value_next = right_value;
                end else if (MY_IDX == cmd.tail) begin
                    value_next = head_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ sv/bounded_ordered_list.sv @@
// Top level of the bounded ordered list: control and the chain of slots.
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries kept in a row of slot
// cells. Every insert or front delete shifts the affected slots by one.
// An item that gives one result is answered in the cycle after it is
// accepted; a new item is taken in the same cycle as that result is taken,
// so such items run at one per cycle when the output never stalls.
// Read-all presents the front slot and rotates the occupied slots by one
// each time a result is taken, so it gives one result per cycle for N
// entries unless the output stalls, and leaves the list as it was; no item
// is accepted during that walk. Status: 0 ok, 1 full, 2 empty, 3 position
// beyond the list. No clearing pass after reset is needed.
module bounded_ordered_list #(
    parameter int DEPTH = bol_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // mode[2:0], value[34:3], position[39:35]
    input  logic [bol_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // item_value[31:0], entry_total[37:32], status[39:38]
    output logic [bol_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready
);
    import bol_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RESP = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] left_reg, left_next;
    status_t          status_reg, status_next;

    mode_t            in_mode;
    logic [VAL_W-1:0] in_value;
    logic [POS_W-1:0] in_pos;
    logic             accept;
    logic             out_take;
    logic             is_full;
    logic             is_empty;
    logic             bad_pos;
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] tail_idx;

    logic [VAL_W-1:0] cell_value [DEPTH];

    assign in_mode  = mode_t'(s_tdata[2:0]);
    assign in_value = s_tdata[34:3];
    assign in_pos   = s_tdata[39:35];

    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_RESP) && m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg != S_IDLE);
    assign out_take = m_tvalid && m_tready;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign bad_pos  = ({3'b000, in_pos} >= 8'(count_reg));
    assign tail_idx = IDX_W'(count_reg - CNT_W'(1));

    // Decode the item into a slot command and the new count / status, and step the read-all walk
    always_comb begin
        cmd         = '{op: OP_HOLD, pos: '0, tail: tail_idx};
        count_next  = count_reg;
        status_next = status_reg;
        left_next   = left_reg;
        state_next  = state_reg;

        unique case (state_reg)
            S_IDLE, S_RESP: begin
                if (state_reg == S_RESP && out_take) begin
                    state_next = S_IDLE;
                end
                if (accept) begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    unique case (in_mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                cmd.op     = OP_INSERT;
                                cmd.pos    = (in_mode == MODE_PUSH_FRONT) ?
                                             '0 : IDX_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_INSERT: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else if (bad_pos) begin
                                status_next = ST_BADPOS;
                            end else begin
                                cmd.op     = OP_INSERT;
                                cmd.pos    = IDX_W'({3'b000, in_pos} + 8'd1);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                // dropping the back needs only the count
                                if (in_mode == MODE_POP_FRONT) begin
                                    cmd.op  = OP_REMOVE;
                                    cmd.pos = '0;
                                end
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        MODE_READ_ALL: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                left_next  = count_reg;
                                state_next = S_READ;
                            end
                        end
                        MODE_COUNT, MODE_SPARE: begin
                            status_next = ST_OK;
                        end
                        default: begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_take) begin
                    cmd.op    = OP_ROTATE;
                    left_next = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [VAL_W-1:0] left_in;
            logic [VAL_W-1:0] right_in;
            if (g == 0) begin : g_first
                assign left_in = in_value;
            end else begin : g_mid_l
                assign left_in = cell_value[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_in = '0;
            end else begin : g_mid_r
                assign right_in = cell_value[g+1];
            end
            bol_cell #(
                .IDX(g)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .ins_value  (in_value),
                .left_value (left_in),
                .right_value(right_in),
                .head_value (cell_value[0]),
                .value      (cell_value[g])
            );
        end
    endgenerate

    always_comb begin
        if (state_reg == S_READ) begin
            m_tdata = {ST_OK, TOTAL_W'(count_reg), cell_value[0]};
            m_tlast = (left_reg == CNT_W'(1));
        end else begin
            m_tdata = {status_reg, TOTAL_W'(count_reg), {VAL_W{1'b0}}};
            m_tlast = 1'b1;
        end
    end

endmodule
